// ----- rtl/window_four_nearest_search_defines.svh -----
// Assertion macros used by the checker of the search block
`ifndef WINDOW_FOUR_NEAREST_SEARCH_DEFINES_SVH
`define WINDOW_FOUR_NEAREST_SEARCH_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define WFNS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted
`define WFNS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wfns_pkg.sv -----
package wfns_pkg;

    localparam int POS_W     = 18;
    localparam int REACH_W   = 16;
    localparam int IMG_W     = 13;
    localparam int IDX_W     = 11;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int RANKS     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = 13'd1280;
    localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } rank_ctl_t;

endpackage

// ----- rtl/window_four_nearest_search.sv -----
// Windowed four-nearest search over a y-sorted target list held in one
// single-port-read RAM. An append word stores one target, unless the list is
// full, in the cycle it is accepted. A query word first runs a halving search
// (one RAM read and one compare per step), then scans one target per cycle from
// the backed-off start up to the first marked target below the window (or
// the list end), then drains the read and distance pipeline and presents the
// result. The RAM read port sets the scan rate. The result waits in an output
// register; a new word is taken while it waits.
module window_four_nearest_search
    import wfns_pkg::*;
#(
    parameter int MAX_TARGETS   = 1024,
    parameter int FRAC_BITS     = 4,
    parameter int START_BACKOFF = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [IMG_W-1:0]       cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic                   s_restart_list,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    input  logic                   s_has_track,
    input  logic [REACH_W-1:0]     s_reach_left,
    input  logic [REACH_W-1:0]     s_reach_right,
    input  logic [REACH_W-1:0]     s_reach_up,
    input  logic [REACH_W-1:0]     s_reach_down,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [IDX_W-1:0] m_nearest_first,
    output logic signed [IDX_W-1:0] m_nearest_second,
    output logic signed [IDX_W-1:0] m_nearest_third,
    output logic signed [IDX_W-1:0] m_nearest_fourth,
    output logic [CNT_W-1:0]       m_found_count
);

    localparam int AW = $clog2(MAX_TARGETS);
    localparam int CW = (FRAC_BITS + 15 > 20) ? FRAC_BITS + 15 : 20;
    localparam int MW = 2 * POS_W + 1;

    state_t state_reg, state_next;

    logic [IMG_W-1:0] img_w_reg, img_h_reg;
    logic [AW:0]      count_reg, count_next;
    logic [AW:0]      j_reg, j_next;
    logic [AW:0]      dj_reg, dj_next;
    logic [AW-1:0]    ridx_reg, ridx_next;
    logic             rv_reg, rv_next;
    logic             stop_reg, stop_next;

    logic             m_valid_reg, m_valid_next;
    logic signed [IDX_W-1:0] out_idx_reg [RANKS];
    logic [CNT_W-1:0] found_reg;

    logic             accept, query_acc, append_acc, load_out;
    logic             issue, scan_done;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [MW-1:0]    ram_wdata, ram_rdata;
    logic [AW:0]      wslot;

    logic signed [CW-1:0] xmin, xmax, ymin, ymax, qx, qy;
    logic signed [POS_W-1:0] rd_x, rd_y;
    logic signed [CW-1:0] tx, ty;
    logic             rd_marked, below, in_window, stop_now, cand;

    rank_ctl_t        rank_ctl;
    logic             rank_busy;
    logic [AW-1:0]    res_idx [RANKS];
    logic [RANKS-1:0] res_val;

    assign accept     = s_valid && s_ready;
    assign query_acc  = accept && (s_kind == KIND_QUERY);
    assign append_acc = accept && (s_kind == KIND_APPEND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= IMAGE_WIDTH_RST;
            img_h_reg <= IMAGE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wfns_window #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_window (
        .aclk        (aclk),
        .load        (query_acc),
        .pos_x       (s_pos_x),
        .pos_y       (s_pos_y),
        .reach_left  (s_reach_left),
        .reach_right (s_reach_right),
        .reach_up    (s_reach_up),
        .reach_down  (s_reach_down),
        .img_w       (img_w_reg),
        .img_h       (img_h_reg),
        .xmin        (xmin),
        .xmax        (xmax),
        .ymin        (ymin),
        .ymax        (ymax),
        .qx          (qx),
        .qy          (qy)
    );

    // word layout: {mark, y, x}
    wfns_ram #(.WIDTH(MW), .DEPTH(MAX_TARGETS)) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        rd_x      = signed'(ram_rdata[POS_W-1:0]);
        rd_y      = signed'(ram_rdata[2*POS_W-1:POS_W]);
        rd_marked = ram_rdata[MW-1];
        tx        = CW'(rd_x);
        ty        = CW'(rd_y);
        below     = ty > ymax;
        in_window = (tx > xmin) && (tx < xmax) && (ty > ymin) && (ty < ymax);
        stop_now  = (state_reg == ST_SCAN) && rv_reg && !stop_reg && rd_marked && below;
        cand      = (state_reg == ST_SCAN) && rv_reg && !stop_reg && rd_marked
                    && !below && in_window;
    end

    assign rank_ctl.clear = query_acc;
    assign rank_ctl.valid = cand;

    wfns_rank #(.CW(CW), .AW(AW)) u_rank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (rank_ctl),
        .idx_in  (ridx_reg),
        .dx      (qx - tx),
        .dy      (qy - ty),
        .busy    (rank_busy),
        .res_idx (res_idx),
        .res_val (res_val)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (query_acc) state_next = ST_SRCH;
            ST_SRCH:     state_next = (dj_reg > (AW+1)'(1)) ? ST_SRCH_CMP : ST_SCAN;
            ST_SRCH_CMP: state_next = ST_SRCH;
            ST_SCAN:     if (scan_done) state_next = ST_FIN;
            ST_FIN:      if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        load_out  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = j_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SRCH: ram_re  = dj_reg > (AW+1)'(1);
            ST_SCAN: begin
                issue  = (j_reg < count_reg) && !stop_reg && !stop_now;
                ram_re = issue;
            end
            ST_FIN:  load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
        scan_done = !issue && !rv_reg && !rank_busy;
    end

    // append path
    always_comb begin
        wslot      = s_restart_list ? '0 : count_reg;
        ram_we     = append_acc && (wslot != (AW+1)'(MAX_TARGETS));
        ram_waddr  = wslot[AW-1:0];
        ram_wdata  = {s_has_track, s_pos_y, s_pos_x};
        count_next = count_reg;
        if (append_acc) begin
            count_next = ram_we ? wslot + (AW+1)'(1) : wslot;
        end
    end

    // search and scan pointers
    always_comb begin
        j_next    = j_reg;
        dj_next   = dj_reg;
        ridx_next = ridx_reg;
        rv_next   = 1'b0;
        stop_next = stop_reg;
        if (query_acc) begin
            j_next    = count_reg >> 1;
            dj_next   = count_reg >> 2;
            stop_next = 1'b0;
        end else if (state_reg == ST_SRCH && !(dj_reg > (AW+1)'(1))) begin
            // back off from the search result, floor at zero
            if (32'(j_reg) < START_BACKOFF) begin
                j_next = '0;
            end else begin
                j_next = j_reg - (AW+1)'(START_BACKOFF);
            end
        end else if (state_reg == ST_SRCH_CMP) begin
            j_next  = (ty < ymin) ? j_reg + dj_reg : j_reg - dj_reg;
            dj_next = dj_reg >> 1;
        end else if (state_reg == ST_SCAN) begin
            if (stop_now) begin
                stop_next = 1'b1;
            end
            if (issue) begin
                j_next    = j_reg + (AW+1)'(1);
                ridx_next = j_reg[AW-1:0];
                rv_next   = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rv_reg      <= 1'b0;
            stop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rv_reg      <= rv_next;
            stop_reg    <= stop_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg    <= j_next;
        dj_reg   <= dj_next;
        ridx_reg <= ridx_next;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            for (int s = 0; s < RANKS; s++) begin
                out_idx_reg[s] <= res_val[s] ? signed'(IDX_W'(res_idx[s])) : '1;
            end
            found_reg <= CNT_W'($countones(res_val));
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_nearest_first  = out_idx_reg[0];
    assign m_nearest_second = out_idx_reg[1];
    assign m_nearest_third  = out_idx_reg[2];
    assign m_nearest_fourth = out_idx_reg[3];
    assign m_found_count    = found_reg;

endmodule

// ----- rtl/wfns_ram.sv -----
module wfns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/wfns_window.sv -----
module wfns_window
    import wfns_pkg::*;
#(
    parameter int FRAC_BITS = 4,
    parameter int CW        = 20
) (
    input  logic                 aclk,
    input  logic                 load,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic [REACH_W-1:0]   reach_left,
    input  logic [REACH_W-1:0]   reach_right,
    input  logic [REACH_W-1:0]   reach_up,
    input  logic [REACH_W-1:0]   reach_down,
    input  logic [IMG_W-1:0]     img_w,
    input  logic [IMG_W-1:0]     img_h,
    output logic signed [CW-1:0] xmin,
    output logic signed [CW-1:0] xmax,
    output logic signed [CW-1:0] ymin,
    output logic signed [CW-1:0] ymax,
    output logic signed [CW-1:0] qx,
    output logic signed [CW-1:0] qy
);

    logic signed [CW-1:0] imx, imy, px, py;
    logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [CW-1:0] xmin_next, xmax_next, ymin_next, ymax_next, qx_next, qy_next;

    always_comb begin
        imx  = signed'(CW'(img_w) << FRAC_BITS);
        imy  = signed'(CW'(img_h) << FRAC_BITS);
        px   = CW'(pos_x);
        py   = CW'(pos_y);
        lo_x = px - signed'(CW'(reach_left));
        hi_x = px + signed'(CW'(reach_right));
        lo_y = py - signed'(CW'(reach_up));
        hi_y = py + signed'(CW'(reach_down));

        xmin_next = (lo_x < 0)   ? '0  : lo_x;
        xmax_next = (hi_x > imx) ? imx : hi_x;
        ymin_next = (lo_y < 0)   ? '0  : lo_y;
        ymax_next = (hi_y > imy) ? imy : hi_y;

        // clamp the point after the window is built from the raw point
        qx_next = (px < 0) ? '0 : ((px > imx) ? imx : px);
        qy_next = (py < 0) ? '0 : ((py > imy) ? imy : py);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            xmin <= xmin_next;
            xmax <= xmax_next;
            ymin <= ymin_next;
            ymax <= ymax_next;
            qx   <= qx_next;
            qy   <= qy_next;
        end
    end

endmodule

// ----- rtl/wfns_rank.sv -----
module wfns_rank
    import wfns_pkg::*;
#(
    parameter int CW = 20,
    parameter int AW = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rank_ctl_t            ctl,
    input  logic [AW-1:0]        idx_in,
    input  logic signed [CW-1:0] dx,
    input  logic signed [CW-1:0] dy,
    output logic                 busy,
    output logic [AW-1:0]        res_idx [RANKS],
    output logic [RANKS-1:0]     res_val
);

    localparam int SW = 2 * CW;
    localparam int DW = SW + 1;

    logic                 v1_reg;
    logic [AW-1:0]        idx1_reg;
    logic [SW-1:0]        sqx_reg, sqy_reg;
    logic signed [SW-1:0] dxw, dyw;

    logic [DW-1:0]        dist_reg [RANKS];
    logic [AW-1:0]        idx_reg  [RANKS];
    logic [RANKS-1:0]     val_reg;

    logic [DW-1:0]        d;
    logic [RANKS-1:0]     lt, gt, take;
    logic                 hit;
    logic [1:0]           slot;

    always_comb begin
        dxw = SW'(dx);
        dyw = SW'(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.valid && !ctl.clear;
        end
        idx1_reg <= idx_in;
        sqx_reg  <= unsigned'(dxw * dxw);
        sqy_reg  <= unsigned'(dyw * dyw);
    end

    always_comb begin
        d = DW'(sqx_reg) + DW'(sqy_reg);
        for (int s = 0; s < RANKS; s++) begin
            lt[s] = !val_reg[s] || (d < dist_reg[s]);
            gt[s] = val_reg[s] && (dist_reg[s] < d);
        end
        // an equal distance is dropped unless strictly between two ranks
        take[0] = lt[0];
        for (int s = 1; s < RANKS; s++) begin
            take[s] = gt[s-1] && lt[s];
        end
        hit  = v1_reg && (take != '0);
        slot = 2'd0;
        for (int s = RANKS - 1; s >= 0; s--) begin
            if (take[s]) begin
                slot = 2'(s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            val_reg <= '0;
        end else if (hit) begin
            if (slot == 2'd0) begin
                val_reg[0] <= 1'b1;
            end
            for (int s = 1; s < RANKS; s++) begin
                if (2'(s) == slot) begin
                    val_reg[s] <= 1'b1;
                end else if (2'(s) > slot) begin
                    val_reg[s] <= val_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            if (slot == 2'd0) begin
                dist_reg[0] <= d;
                idx_reg[0]  <= idx1_reg;
            end
            for (int s = 1; s < RANKS; s++) begin
                if (2'(s) == slot) begin
                    dist_reg[s] <= d;
                    idx_reg[s]  <= idx1_reg;
                end else if (2'(s) > slot) begin
                    dist_reg[s] <= dist_reg[s-1];
                    idx_reg[s]  <= idx_reg[s-1];
                end
            end
        end
    end

    assign busy    = v1_reg;
    assign res_idx = idx_reg;
    assign res_val = val_reg;

endmodule

// ----- rtl/wfns_checker.sv -----
`include "window_four_nearest_search_defines.svh"

module wfns_checker
    import wfns_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_kind,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [IDX_W-1:0] m_nearest_first,
    input logic signed [IDX_W-1:0] m_nearest_second,
    input logic signed [IDX_W-1:0] m_nearest_third,
    input logic signed [IDX_W-1:0] m_nearest_fourth,
    input logic [CNT_W-1:0]        m_found_count
);

    logic [RANKS-1:0] filled;

    assign filled = {m_nearest_fourth != '1, m_nearest_third != '1,
                     m_nearest_second != '1, m_nearest_first != '1};

    `WFNS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_nearest_first) && $stable(m_found_count),
        "result word changed while stalled")

    `WFNS_ASSERT_NOW(a_count_match, aclk, aresetn, m_valid,
        32'(m_found_count) == $countones(filled),
        "found count disagrees with the indices")

    `WFNS_ASSERT_NOW(a_ranks_packed, aclk, aresetn, m_valid,
        (filled[3] == 1'b0 || filled[2]) && (filled[2] == 1'b0 || filled[1])
        && (filled[1] == 1'b0 || filled[0]),
        "a farther rank is filled while a nearer one is empty")

    `WFNS_ASSERT_NEXT(a_append_one_cycle, aclk, aresetn,
        s_valid && s_ready && s_kind == KIND_APPEND, s_ready,
        "append word did not complete in one cycle")

endmodule

bind window_four_nearest_search wfns_checker u_wfns_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import wfns_pkg::*;

    localparam int LIST_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic                    kind;
        logic                    restart;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    track;
        logic [REACH_W-1:0]      rl;
        logic [REACH_W-1:0]      rr;
        logic [REACH_W-1:0]      ru;
        logic [REACH_W-1:0]      rd;
    } search_word_t;

    typedef struct {
        logic [IDX_W-1:0] idx [RANKS];
        logic [CNT_W-1:0] cnt;
    } nearest_t;

    class search_scoreboard;
        int       tgt_x [LIST_DEPTH];
        int       tgt_y [LIST_DEPTH];
        bit       tgt_mark [LIST_DEPTH];
        int       count;
        int       img_w;
        int       img_h;
        nearest_t pending [$];
        int       errors;

        function new();
            count = 0;
            img_w = IMAGE_WIDTH_RST;
            img_h = IMAGE_HEIGHT_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int val);
            if (idx == CFG_IMAGE_WIDTH) img_w = val & 'h1FFF;
            else if (idx == CFG_IMAGE_HEIGHT) img_h = val & 'h1FFF;
        endfunction

        function void note_word(search_word_t w);
            int imx, imy, px, py, xmin, xmax, ymin, ymax, j0, dj, tx, ty, slot;
            int rank_idx [RANKS];
            logic [63:0] rank_d [RANKS];
            logic [63:0] d;
            longint dx, dy;
            nearest_t r;
            px = w.x;
            py = w.y;
            if (w.kind == KIND_APPEND) begin
                if (w.restart) count = 0;
                if (count < LIST_DEPTH) begin
                    tgt_x[count] = px;
                    tgt_y[count] = py;
                    tgt_mark[count] = w.track;
                    count++;
                end
                return;
            end
            imx = img_w << 4;
            imy = img_h << 4;
            xmin = px - int'(w.rl);
            xmax = px + int'(w.rr);
            ymin = py - int'(w.ru);
            ymax = py + int'(w.rd);
            if (xmin < 0) xmin = 0;
            if (xmax > imx) xmax = imx;
            if (ymin < 0) ymin = 0;
            if (ymax > imy) ymax = imy;
            px = (px < 0) ? 0 : (px > imx) ? imx : px;
            py = (py < 0) ? 0 : (py > imy) ? imy : py;
            j0 = count / 2;
            for (dj = count / 4; dj > 1; dj = dj / 2) begin
                if (tgt_y[j0] < ymin) j0 += dj;
                else j0 -= dj;
            end
            j0 -= 12;
            if (j0 < 0) j0 = 0;
            for (int s = 0; s < RANKS; s++) begin
                rank_idx[s] = -1;
                rank_d[s] = '1;
            end
            for (int j = j0; j < count; j++) begin
                if (!tgt_mark[j]) continue;
                tx = tgt_x[j];
                ty = tgt_y[j];
                if (ty > ymax) break;
                if (!(tx > xmin && tx < xmax && ty > ymin && ty < ymax)) continue;
                dx = px - tx;
                dy = py - ty;
                d = dx * dx + dy * dy;
                slot = -1;
                if (d < rank_d[0]) slot = 0;
                else if (rank_d[0] < d && d < rank_d[1]) slot = 1;
                else if (rank_d[1] < d && d < rank_d[2]) slot = 2;
                else if (rank_d[2] < d && d < rank_d[3]) slot = 3;
                if (slot >= 0) begin
                    for (int s = RANKS - 1; s > slot; s--) begin
                        rank_idx[s] = rank_idx[s-1];
                        rank_d[s] = rank_d[s-1];
                    end
                    rank_idx[slot] = j;
                    rank_d[slot] = d;
                end
            end
            r.cnt = 0;
            for (int s = 0; s < RANKS; s++) begin
                r.idx[s] = rank_idx[s][IDX_W-1:0];
                if (rank_idx[s] != -1) r.cnt++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(nearest_t got);
            nearest_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word cnt=%0d", $time, got.cnt);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int s = 0; s < RANKS; s++)
                if (got.idx[s] !== want.idx[s]) begin
                    $display("%0t: rank %0d expected %0d actual %0d", $time, s,
                             $signed(want.idx[s]), $signed(got.idx[s]));
                    errors++;
                end
            if (got.cnt !== want.cnt) begin
                $display("%0t: found_count expected %0d actual %0d", $time,
                         want.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [IMG_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_kind;
    logic                    s_restart_list;
    logic signed [POS_W-1:0] s_pos_x;
    logic signed [POS_W-1:0] s_pos_y;
    logic                    s_has_track;
    logic [REACH_W-1:0]      s_reach_left;
    logic [REACH_W-1:0]      s_reach_right;
    logic [REACH_W-1:0]      s_reach_up;
    logic [REACH_W-1:0]      s_reach_down;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [IDX_W-1:0] m_nearest_first;
    logic signed [IDX_W-1:0] m_nearest_second;
    logic signed [IDX_W-1:0] m_nearest_third;
    logic signed [IDX_W-1:0] m_nearest_fourth;
    logic [CNT_W-1:0]        m_found_count;

    window_four_nearest_search u_top (.*);

    search_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        nearest_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (aresetn) begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (m_valid && m_ready) begin
                got.idx[0] = m_nearest_first;
                got.idx[1] = m_nearest_second;
                got.idx[2] = m_nearest_third;
                got.idx[3] = m_nearest_fourth;
                got.cnt = m_found_count;
                sb.check_result(got);
            end
        end
    end

    task automatic send_word(search_word_t w);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_kind <= w.kind;
        s_restart_list <= w.restart;
        s_pos_x <= w.x;
        s_pos_y <= w.y;
        s_has_track <= w.track;
        s_reach_left <= w.rl;
        s_reach_right <= w.rr;
        s_reach_up <= w.ru;
        s_reach_down <= w.rd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic append(int x, int y, bit mark, bit restart);
        search_word_t w;
        w = '{KIND_APPEND, restart, POS_W'(x), POS_W'(y), mark,
              REACH_W'($urandom), REACH_W'($urandom), REACH_W'($urandom),
              REACH_W'($urandom)};
        send_word(w);
    endtask

    task automatic query(int x, int y, int rl, int rr, int ru, int rd);
        search_word_t w;
        w = '{KIND_QUERY, 1'($urandom), POS_W'(x), POS_W'(y), 1'($urandom),
              REACH_W'(rl), REACH_W'(rr), REACH_W'(ru), REACH_W'(rd)};
        send_word(w);
    endtask

    // hold the sender until every result is back, then let appends settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= IMG_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_image(int w, int h);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    function automatic int pos_clip(int v);
        return (v > 131071) ? 131071 : (v < -65536) ? -65536 : v;
    endfunction

    function automatic int pick_reach(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        return $urandom_range(0, span / 3 + 32);
    endfunction

    // mostly sorted list with random content and some random words, then a burst of queries over it
    task automatic random_block();
        int imx, imy, n, y, step;
        imx = sb.img_w * 16;
        imy = sb.img_h * 16;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 16);
        y = $urandom_range(0, imy / 4 + 32) - 32;
        step = 2 * (imy + 64) / (n + 1) + 2;
        append(pos_clip($urandom_range(0, imx + 64) - 32), pos_clip(y),
               $urandom_range(0, 5) != 0, 1'b1);
        for (int i = 1; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word('{1'($urandom), 1'($urandom), POS_W'($urandom),
                            POS_W'($urandom), 1'($urandom), REACH_W'($urandom),
                            REACH_W'($urandom), REACH_W'($urandom),
                            REACH_W'($urandom)});
            end else begin
                y += $urandom_range(0, step);
                append(pos_clip($urandom_range(0, imx + 64) - 32), pos_clip(y),
                       $urandom_range(0, 5) != 0, 1'b0);
            end
        end
        repeat ($urandom_range(2, 8))
            query(pos_clip($urandom_range(0, imx + 64) - 32),
                  pos_clip($urandom_range(0, imy + 64) - 32),
                  pick_reach(imx), pick_reach(imx), pick_reach(imy), pick_reach(imy));
    endtask

    initial begin
        int phase_idle [4] = '{0, 54, 0, 12};
        int phase_stall [4] = '{0, 0, 54, 12};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_kind = KIND_APPEND;
        s_restart_list = 1'b0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_has_track = 1'b0;
        s_reach_left = '0;
        s_reach_right = '0;
        s_reach_up = '0;
        s_reach_down = '0;
        m_ready = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list
        query(1000, 1000, 65535, 65535, 65535, 65535);
        // extremes of position, plus an unmarked target
        append(131071, 131071, 1'b1, 1'b1);
        append(-65536, -65536, 1'b1, 1'b0);
        append(160, 100, 1'b0, 1'b0);
        // two targets at equal distance: the second is dropped
        append(200, 200, 1'b1, 1'b0);
        append(220, 200, 1'b1, 1'b0);
        append(180, 200, 1'b1, 1'b0);
        append(200, 230, 1'b1, 1'b0);
        append(200, 240, 1'b1, 1'b0);
        append(200, 250, 1'b1, 1'b0);
        query(200, 200, 100, 100, 100, 100);
        query(-65536, -65536, 65535, 65535, 65535, 65535);
        query(131071, 131071, 0, 0, 0, 0);
        query(200, 210, 30, 30, 15, 45);
        // zero image size finds nothing
        set_image(0, 0);
        query(200, 200, 65535, 65535, 65535, 65535);
        set_image(8191, 8191);
        query(131071, 131071, 65535, 65535, 65535, 65535);
        set_image(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST);

        // longer sorted list searched from the middle, then a restart leaves one target
        append(16, 16, 1'b1, 1'b1);
        for (int i = 1; i < 48; i++) append(16 + i * 3, 16 + i * 16, i % 3 != 0, 1'b0);
        query(100, 400, 400, 400, 400, 400);
        query(150, 700, 200, 200, 60, 200);
        append(50, 50, 1'b1, 1'b1);
        query(48, 48, 16, 16, 16, 16);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_image(4096, 4096);
                1: set_image(1, 1);
                2: set_image($urandom_range(1, 4096), $urandom_range(1, 4096));
                default: set_image(IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST);
            endcase
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int b = 0; b < 5; b++) begin
                random_block();
                if (b == 3) set_image($urandom_range(1, 4096), $urandom_range(1, 4096));
            end
        end

        idle_pct = 0;
        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wfns_pkg.sv
rtl/wfns_ram.sv
rtl/wfns_window.sv
rtl/wfns_rank.sv
rtl/window_four_nearest_search.sv
rtl/wfns_checker.sv
tb/sv/tb.sv
